// ----- rtl/core/text_console_writer_macros.svh -----
// Assertion macros shared by the text console checker.
// Plain text only; no dependencies.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console check failed");

`endif

// ----- rtl/core/tcw_pkg.sv -----
// Shared types and constants of the text console writer.
// No dependencies.
package tcw_pkg;

  localparam int CELL_W = 12;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int DATA_W = 16;

  typedef logic [CELL_W-1:0] cell_idx_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [DATA_W-1:0] cell_data_t;

  localparam logic [1:0] KIND_PUT_CUR = 2'd0;
  localparam logic [1:0] KIND_PUT_AT  = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ERROR   = 8'h45;
  localparam logic [7:0] ATTR_BLANK = 8'h0F;
  localparam logic [7:0] ATTR_ERROR = 8'hF4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    col_t       column;
    row_t       row;
    logic [7:0] attribute;
  } in_item_t;

  typedef struct packed {
    cell_idx_t  cursor_cell;
    cell_idx_t  position;
    logic       out_of_range;
    logic [7:0] read_char;
    logic [7:0] read_attr;
  } out_item_t;

  // Cell store access issued by the sequencer; data is {attribute, char}.
  typedef struct packed {
    logic       we;
    cell_idx_t  waddr;
    cell_data_t wdata;
    logic       re;
    cell_idx_t  raddr;
  } mem_req_t;

endpackage

// ----- rtl/core/tcw_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/tcw_seq.sv -----
// Sequencer of the text console: cursor, item decode, cell store sweeps.
// Depends on tcw_pkg; drives the cell store RAM through a mem_req_t.
module tcw_seq #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  tcw_pkg::in_item_t    in_item,
  output logic                 in_stall,
  input  logic                 out_free,
  output logic                 res_valid,
  output tcw_pkg::out_item_t   res_item,
  output tcw_pkg::mem_req_t    mem_req,
  input  tcw_pkg::cell_data_t  mem_rdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam tcw_pkg::cell_idx_t LAST_CELL = tcw_pkg::cell_idx_t'(CELLS - 1);
  localparam tcw_pkg::cell_idx_t KEEP_CELLS = tcw_pkg::cell_idx_t'(CELLS - COLUMNS);
  localparam tcw_pkg::cell_idx_t ROW_CELLS = tcw_pkg::cell_idx_t'(COLUMNS);
  localparam tcw_pkg::row_t LAST_ROW = tcw_pkg::row_t'(ROWS - 1);
  localparam tcw_pkg::col_t LAST_COL = tcw_pkg::col_t'(COLUMNS - 1);
  localparam logic [tcw_pkg::ROW_W:0] ROW_LIMIT = ROWS[tcw_pkg::ROW_W:0];

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;

  logic [2:0]          state_r, state_nxt;
  tcw_pkg::in_item_t   item_r, item_nxt;
  tcw_pkg::row_t       crow_r, crow_nxt;
  tcw_pkg::col_t       ccol_r, ccol_nxt;
  tcw_pkg::cell_idx_t  ptr_r, ptr_nxt;
  logic                res_pend_r, res_pend_nxt;
  tcw_pkg::out_item_t  res_r, res_nxt;

  logic                accept;
  logic [7:0]          attr_eff;
  logic                outside;
  logic                newline;
  tcw_pkg::cell_idx_t  index;
  tcw_pkg::row_t       prow;
  tcw_pkg::col_t       pcol;
  tcw_pkg::cell_idx_t  pos;
  logic [tcw_pkg::ROW_W:0] nrow;
  tcw_pkg::col_t       ncol;
  logic                wrap;
  tcw_pkg::cell_idx_t  cur_cell;
  tcw_pkg::cell_idx_t  step_cell;
  tcw_pkg::cell_idx_t  ptr_inc;

  function automatic tcw_pkg::cell_idx_t cell_of(tcw_pkg::row_t r, tcw_pkg::col_t c);
    cell_of = tcw_pkg::cell_idx_t'(32'(r) * COLUMNS + 32'(c));
  endfunction

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE) || (res_pend_r && !out_free);
  assign res_valid = res_pend_r;
  assign res_item  = res_r;

  // Decode of the item being worked on.
  assign attr_eff = (item_r.attribute == 8'h00) ? tcw_pkg::ATTR_BLANK : item_r.attribute;
  assign outside  = (32'(item_r.column) >= COLUMNS) || (32'(item_r.row) >= ROWS);
  assign newline  = (item_r.ch == tcw_pkg::CH_NEWLINE);
  assign index    = cell_of(item_r.row, item_r.column);
  assign prow     = (item_r.kind == tcw_pkg::KIND_PUT_AT) ? item_r.row : crow_r;
  assign pcol     = (item_r.kind == tcw_pkg::KIND_PUT_AT) ? item_r.column : ccol_r;
  assign pos      = cell_of(prow, pcol);
  assign cur_cell = cell_of(crow_r, ccol_r);
  assign ptr_inc  = ptr_r + 1'b1;

  // Cursor advance: a newline or the last column goes to the next row.
  always_comb begin
    if (newline || (pcol == LAST_COL)) begin
      nrow = {1'b0, prow} + 1'b1;
      ncol = '0;
    end else begin
      nrow = {1'b0, prow};
      ncol = pcol + 1'b1;
    end
  end

  assign wrap      = (nrow == ROW_LIMIT);
  assign step_cell = cell_of(nrow[tcw_pkg::ROW_W-1:0], ncol);

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    crow_nxt     = crow_r;
    ccol_nxt     = ccol_r;
    ptr_nxt      = ptr_r;
    res_nxt      = res_r;
    res_pend_nxt = res_pend_r && !out_free;
    mem_req      = '0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = {tcw_pkg::ATTR_BLANK, tcw_pkg::CH_SPACE};
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_inc;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          item_nxt  = in_item;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (item_r.kind)
          tcw_pkg::KIND_PUT_CUR, tcw_pkg::KIND_PUT_AT: begin
            if ((item_r.kind == tcw_pkg::KIND_PUT_AT) && outside) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = LAST_CELL;
              mem_req.wdata = {tcw_pkg::ATTR_ERROR, tcw_pkg::CH_ERROR};
              res_nxt       = '{cur_cell, index, 1'b1, 8'h00, 8'h00};
              res_pend_nxt  = 1'b1;
              state_nxt     = ST_IDLE;
            end else begin
              if (!newline) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos;
                mem_req.wdata = {attr_eff, item_r.ch};
              end
              if (wrap) begin
                // Prefetch the first source cell of the scroll.
                crow_nxt      = LAST_ROW;
                ccol_nxt      = '0;
                ptr_nxt       = '0;
                mem_req.re    = 1'b1;
                mem_req.raddr = ROW_CELLS;
                state_nxt     = ST_SCROLL;
              end else begin
                crow_nxt     = nrow[tcw_pkg::ROW_W-1:0];
                ccol_nxt     = ncol;
                res_nxt      = '{step_cell, step_cell, 1'b0, 8'h00, 8'h00};
                res_pend_nxt = 1'b1;
                state_nxt    = ST_IDLE;
              end
            end
          end
          tcw_pkg::KIND_READ: begin
            if (outside) begin
              res_nxt      = '{cur_cell, index, 1'b1, 8'h00, 8'h00};
              res_pend_nxt = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = index;
              state_nxt     = ST_READ;
            end
          end
          tcw_pkg::KIND_CLEAR: begin
            crow_nxt     = '0;
            ccol_nxt     = '0;
            ptr_nxt      = '0;
            res_nxt      = '0;
            res_pend_nxt = 1'b1;
            state_nxt    = ST_CLEAR;
          end
        endcase
      end

      ST_READ: begin
        res_nxt      = '{cur_cell, index, 1'b0, mem_rdata[7:0], mem_rdata[15:8]};
        res_pend_nxt = 1'b1;
        state_nxt    = ST_IDLE;
      end

      ST_SCROLL: begin
        // Cell ptr takes the cell one row below; the bottom row becomes zero.
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = (ptr_r < KEEP_CELLS) ? mem_rdata : '0;
        if (ptr_inc < KEEP_CELLS) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_inc + ROW_CELLS;
        end
        if (ptr_r == LAST_CELL) begin
          ptr_nxt      = '0;
          res_nxt      = '{cur_cell, cur_cell, 1'b0, 8'h00, 8'h00};
          res_pend_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          ptr_nxt = ptr_inc;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      crow_r     <= '0;
      ccol_r     <= '0;
      ptr_r      <= '0;
      res_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      crow_r     <= crow_nxt;
      ccol_r     <= ccol_nxt;
      ptr_r      <= ptr_nxt;
      res_pend_r <= res_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ----- rtl/core/text_console_writer.sv -----
// Text console writer: a put is taken in the idle state and worked in the exec state,
// and a new item is taken only back in idle; results go through the sequencer's result
// register to the output register. An on-screen read also passes a read state for the
// RAM read. A put past the last row adds a scroll over all cells; a clear walks them too.
// Reset (rst_n low, synchronous) homes the cursor and starts a clearing pass over all
// COLUMNS*ROWS cells that fills the store with blanks while in_stall stays high.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_item_t out_item
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  tcw_pkg::mem_req_t   mem_req;
  tcw_pkg::cell_data_t mem_rdata;
  logic                res_valid;
  tcw_pkg::out_item_t  res_item;
  logic                out_free;
  logic                out_valid_r, out_valid_nxt;
  tcw_pkg::out_item_t  out_item_r;

  // The sequencer owns the cursor and all cell store traffic. It hands over one
  // finished result at a time and holds it until the output register is free.
  tcw_seq #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .out_free (out_free),
    .res_valid(res_valid),
    .res_item (res_item),
    .mem_req  (mem_req),
    .mem_rdata(mem_rdata)
  );

  // The cell store: one character byte and one attribute byte per cell.
  // Read data is registered and arrives in the cycle after the read is issued.
  tcw_ram #(
    .WIDTH(tcw_pkg::DATA_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr[AW-1:0]),
    .wdata(mem_req.wdata),
    .re   (mem_req.re),
    .raddr(mem_req.raddr[AW-1:0]),
    .rdata(mem_rdata)
  );

  // The output register separates the result side from the input side: while a
  // result waits here for its transfer, the sequencer already takes the next item.
  // It refills in the same cycle that its current contents transfer.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // The payload only loads when a new result moves in, so it holds while stalled.
  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/core/tcw_checker.sv -----
// Port-level checks of the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_macros.svh.
`include "text_console_writer_macros.svh"

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tcw_pkg::out_item_t out_item
);

  localparam int CELLS = COLUMNS * ROWS;

  // A stalled result keeps its place and its value.
  `TCW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))

  // Items are worked one at a time: an input transfer is followed by a busy cycle.
  `TCW_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)

  // The cursor never leaves the screen.
  `TCW_ASSERT_SAME(a_cursor_on_screen, clk, rst_n, out_valid, 32'(out_item.cursor_cell) < CELLS)

  // A coordinate error never comes with read data.
  `TCW_ASSERT_SAME(a_error_no_data, clk, rst_n, out_valid && out_item.out_of_range, (out_item.read_char == 8'h00) && (out_item.read_attr == 8'h00))

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);
